### design/mete_pkg.sv
// shared types and constants for the missed event table
// entry layout, per-cell commands, sequencer states, action and result codes, limits and register addresses
// no dependencies
`default_nettype none
package mete_pkg;

  // caller in the lowest bits, flags in the highest
  typedef struct packed {
    logic [7:0]  flags;
    logic [7:0]  count;
    logic [15:0] id;
    logic [31:0] time_s;
    logic [63:0] caller;
  } entry_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_RIGHT,
    C_LEFT,
    C_LOAD,
    C_BUMP
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPIRE,
    S_ACT,
    S_MOVE,
    S_FULL2,
    S_READ,
    S_FINISH
  } state_t;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_LISTED = 2'd1;
  localparam logic [1:0] KIND_NOTICE = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic [7:0]  COUNT_LIMIT       = 8'd255;
  localparam logic [5:0]  RESET_EVENT_LIMIT = 6'd20;
  localparam logic [31:0] RESET_LIFETIME    = 32'd86400;

  localparam logic [0:0] REG_EVENT_LIMIT = 1'b0;
  localparam logic [0:0] REG_LIFETIME    = 1'b1;

endpackage
`default_nettype wire

### design/missed_event_table_with_expiry.sv
// channel  dir  handshake            payload
// s_axis   in   tvalid/tready        tuser action, tdata now/event time, caller, flags, id
// m_axis   out  tvalid/tready/tlast  tuser kind, tdata caller, time, id, count, flags
// apb      in   psel/penable/pready  reg 0 event_limit, reg 4 event_lifetime
// one item at a time: accept, expiry check that drops each expired head entry,
// action and closing; a repeat caller also slides its entry slot by slot, a read
// lists each entry in turn, and an eviction adds a step of its own
// the cell row shifts one place per cycle unless a stalled output holds it
// reset restores the fill count, state, output valid and config; cells hold stale data until written
// a stalled output holds the sequencer when it has a word to give; input waits
`default_nettype none
module missed_event_table_with_expiry #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [151:0] s_axis_tdata,  // now_time, event_time, caller_key, call_flags, target_id
  input  wire  [1:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata,  // out_caller, out_time, out_id, out_count, out_flags
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mete_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int TW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    entry_t     ent;
  } res_t;

  // configuration
  logic [5:0]  event_limit;
  logic [31:0] event_lifetime;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LIFETIME) ? event_lifetime : {26'd0, event_limit};

  // latched item
  logic [1:0]  act;
  logic [31:0] now_t;
  logic [31:0] when_t;
  logic [63:0] key;
  logic [7:0]  flags;
  logic [15:0] tid;

  state_t          state, state_next;
  logic [TW-1:0]   total, total_next;
  logic [IW-1:0]   pos, pos_next;
  logic [TW-1:0]   rd_cnt, rd_cnt_next;
  logic            hold_valid;
  res_t            hold;

  entry_t    cq  [TABLE_DEPTH];
  cell_cmd_t cmd [TABLE_DEPTH];
  entry_t    ext;

  logic [TABLE_DEPTH-1:0] hit_key, hit_id, lt_when;
  logic [IW-1:0] key_idx, id_idx;
  logic [6:0]    lim;
  logic          can_emit, expired;
  logic          prod, fin;
  res_t          prod_res;
  entry_t        tail, c0;
  logic [15:0]   next_id;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_row
      entry_t lft, rgt;
      if (g == 0) begin : g_first
        assign lft = '0;
      end else begin : g_mid_l
        assign lft = cq[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
        assign rgt = '0;
      end else begin : g_mid_r
        assign rgt = cq[g+1];
      end
      mete_cell u_cell (
        .clk   (clk),
        .cmd   (cmd[g]),
        .left  (lft),
        .right (rgt),
        .ext   (ext),
        .q     (cq[g])
      );
      assign hit_key[g] = (TW'(g) < total) && (cq[g].caller == key);
      assign hit_id[g]  = (TW'(g) < total) && (cq[g].id == tid);
      assign lt_when[g] = cq[g].time_s < when_t;
    end
  endgenerate

  // first hit wins
  always_comb begin
    key_idx = '0;
    id_idx  = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (hit_key[k]) key_idx = IW'(k);
      if (hit_id[k])  id_idx  = IW'(k);
    end
  end

  assign c0   = cq[0];
  assign tail = cq[IW'(total - TW'(1))];
  assign lim  = (event_limit == 6'd0) ? 7'd1 :
                ({1'b0, event_limit} > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) :
                {1'b0, event_limit};
  assign expired  = (total != '0) &&
                    (({1'b0, c0.time_s} + {1'b0, event_lifetime}) < {1'b0, now_t});
  assign can_emit = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_EXPIRE;
      S_EXPIRE: if (!expired) state_next = S_ACT;
      S_ACT: begin
        case (act)
          ACT_ADD: begin
            if (|hit_key) state_next = S_MOVE;
            else if ({{(7-TW){1'b0}}, total} >= lim) begin
              if (can_emit) state_next = S_FULL2;
            end else state_next = S_FINISH;
          end
          ACT_READ: begin
            if (total != '0) state_next = S_READ;
            else if (can_emit) state_next = S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_MOVE:
        if (!((TW'(pos) + TW'(1) < total) && lt_when[IW'(pos + IW'(1))]))
          state_next = S_FINISH;
      S_FULL2:  if (can_emit) state_next = S_FINISH;
      S_READ:   if (can_emit && rd_cnt == total - TW'(1)) state_next = S_FINISH;
      S_FINISH: if (can_emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: cell commands, results, counters
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) cmd[k] = C_HOLD;
    total_next  = total;
    pos_next    = pos;
    rd_cnt_next = rd_cnt;
    prod        = 1'b0;
    prod_res    = '0;
    fin         = 1'b0;
    next_id     = (total > TW'(0)) ? tail.id + 16'd1 : 16'd0;
    ext         = '{caller: key, time_s: when_t, id: next_id, count: 8'd1, flags: flags};
    case (state)
      S_EXPIRE: begin
        if (expired && can_emit) begin
          prod = 1'b1;
          prod_res.kind = KIND_NOTICE;
          prod_res.ent.caller = c0.caller;
          for (int k = 0; k < TABLE_DEPTH; k++) cmd[k] = C_RIGHT;
          total_next = total - TW'(1);
        end
      end
      S_ACT: begin
        case (act)
          ACT_ADD: begin
            if (|hit_key) begin
              cmd[key_idx] = C_BUMP;
              pos_next = key_idx;
            end else if ({{(7-TW){1'b0}}, total} >= lim) begin
              if (can_emit) begin
                prod = 1'b1;
                prod_res.kind = KIND_NOTICE;
                prod_res.ent.caller = key;
              end
            end else begin
              cmd[IW'(total)] = C_LOAD;
              total_next = total + TW'(1);
            end
          end
          ACT_REMOVE: begin
            if (|hit_id) begin
              for (int k = 0; k < TABLE_DEPTH; k++)
                if (IW'(k) >= id_idx) cmd[k] = C_RIGHT;
              total_next = total - TW'(1);
            end
          end
          ACT_READ: begin
            rd_cnt_next = '0;
            if (total == '0 && can_emit) begin
              prod = 1'b1;
              prod_res.kind = KIND_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_MOVE: begin
        // bubble the bumped entry later while its right neighbor is older
        if ((TW'(pos) + TW'(1) < total) && lt_when[IW'(pos + IW'(1))]) begin
          cmd[pos] = C_RIGHT;
          cmd[IW'(pos + IW'(1))] = C_LEFT;
          pos_next = pos + IW'(1);
        end
      end
      S_FULL2: begin
        // evict head and append the new caller behind the shifted row
        next_id = (total > TW'(1)) ? tail.id + 16'd1 : 16'd0;
        ext.id  = next_id;
        if (can_emit) begin
          prod = 1'b1;
          prod_res.kind = KIND_NOTICE;
          prod_res.ent.caller = c0.caller;
          for (int k = 0; k < TABLE_DEPTH; k++) cmd[k] = C_RIGHT;
          cmd[IW'(total - TW'(1))] = C_LOAD;
        end
      end
      S_READ: begin
        // rotate the filled part of the row, head word goes out
        ext = c0;
        if (can_emit) begin
          prod = 1'b1;
          prod_res.kind = KIND_LISTED;
          prod_res.ent  = c0;
          for (int k = 0; k < TABLE_DEPTH; k++)
            if (TW'(k) + TW'(1) < total) cmd[k] = C_RIGHT;
          cmd[IW'(total - TW'(1))] = C_LOAD;
          rd_cnt_next = rd_cnt + TW'(1);
        end
      end
      S_FINISH: fin = can_emit;
      default: ;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      total          <= '0;
      hold_valid     <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      event_limit    <= RESET_EVENT_LIMIT;
      event_lifetime <= RESET_LIFETIME;
    end else begin
      state  <= state_next;
      total  <= total_next;
      pos    <= pos_next;
      rd_cnt <= rd_cnt_next;
      if (cfg_wr) begin
        if (paddr[2] == REG_EVENT_LIMIT) event_limit <= pwdata[5:0];
        else event_lifetime <= pwdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        act    <= s_axis_tuser;
        now_t  <= s_axis_tdata[31:0];
        when_t <= s_axis_tdata[63:32];
        key    <= s_axis_tdata[127:64];
        flags  <= s_axis_tdata[135:128];
        tid    <= s_axis_tdata[151:136];
      end
      // one result held back so the last mark is known when it leaves
      if (prod) begin
        hold       <= prod_res;
        hold_valid <= 1'b1;
        if (hold_valid) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tuser  <= hold.kind;
          m_axis_tdata  <= hold.ent;
          m_axis_tlast  <= 1'b0;
        end else if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
      end else if (fin) begin
        hold_valid    <= 1'b0;
        m_axis_tvalid <= 1'b1;
        m_axis_tlast  <= 1'b1;
        m_axis_tuser  <= hold_valid ? hold.kind : KIND_DONE;
        m_axis_tdata  <= hold_valid ? hold.ent : '0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(TABLE_DEPTH)) else $error("fill count beyond depth");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !hold_valid) else $error("result left over at idle");
  a_move_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (TW'(pos) < total)) else $error("slide beyond fill");
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(total)) else $error("fill changed while idle");
`endif

endmodule
`default_nettype wire

### design/mete_cell.sv
// one table cell: holds an entry and takes a neighbor's or an external one
// depends on mete_pkg
`default_nettype none
module mete_cell (
  input  wire                      clk,
  input  wire mete_pkg::cell_cmd_t cmd,
  input  wire mete_pkg::entry_t    left,
  input  wire mete_pkg::entry_t    right,
  input  wire mete_pkg::entry_t    ext,
  output mete_pkg::entry_t         q
);
  import mete_pkg::*;

  entry_t q_next;

  always_comb begin
    q_next = q;
    case (cmd)
      C_HOLD:  q_next = q;
      C_RIGHT: q_next = right;
      C_LEFT:  q_next = left;
      C_LOAD:  q_next = ext;
      C_BUMP: begin
        // repeat caller: saturating count, new time
        q_next.time_s = ext.time_s;
        if (q.count != COUNT_LIMIT) q_next.count = q.count + 8'd1;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire
